// ===== design/dag_dependency_tracker_topo_sort_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the task dependency graph block
// ---------------------------------------------------------------------------
`ifndef DAG_DEPENDENCY_TRACKER_TOPO_SORT_TOP_MACROS_SVH
`define DAG_DEPENDENCY_TRACKER_TOPO_SORT_TOP_MACROS_SVH

// a implies b in the same cycle
`define DTS_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// a implies b in the next cycle
`define DTS_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== design/dts_pkg.sv =====
// ---------------------------------------------------------------------------
// dts_pkg
// Types, constants and helpers of the task dependency graph block.
// ---------------------------------------------------------------------------
package dts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDW = $clog2(MAX_TASKS + 1);
  localparam int SW  = $clog2(MAX_TASKS);
  localparam int CW  = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    FN_ADD_TASK = 3'd0,
    FN_ADD_EDGE = 3'd1,
    FN_SORT     = 3'd2,
    FN_CLEAR    = 3'd3,
    FN_DEGREE   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REACH,
    S_DEG,
    S_SCAN,
    S_SEED,
    S_SORT,
    S_EMIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] func;
    logic [1:0] device;
    logic [4:0] from_id;
    logic [4:0] to_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] task_id;
    logic [1:0] task_device;
    logic [3:0] in_count;
    logic [3:0] out_count;
    logic       acyclic;
    logic       last;
  } out_word_t;

  // row command broadcast to the cells
  typedef struct packed {
    logic                 clear;
    logic                 add_en;
    logic [SW-1:0]        add_slot;
    logic [1:0]           add_dev;
    logic                 edge_en;
    logic [SW-1:0]        edge_row;
    logic [MAX_TASKS-1:0] edge_bit;
    logic                 cnt_load;
    logic                 release_en;
    logic [MAX_TASKS-1:0] release_mask;
  } cell_cmd_t;

  function automatic logic [3:0] sat15(input logic [CW-1:0] v);
    logic [3:0] r;
    if (v > CW'(15)) r = 4'd15;
    else r = v[3:0];
    return r;
  endfunction

endpackage

// ===== design/dts_cell.sv =====
// ---------------------------------------------------------------------------
// dts_cell
// One task slot: used flag, device tag, edge row and a pending predecessor
// count.
// ---------------------------------------------------------------------------
module dts_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [dts_pkg::SW-1:0]        slot,
  input  dts_pkg::cell_cmd_t            cmd,
  input  logic [dts_pkg::MAX_TASKS-1:0] col_in,
  output logic [dts_pkg::MAX_TASKS-1:0] row_out,
  output logic                          used,
  output logic [1:0]                    dev,
  output logic [dts_pkg::CW-1:0]        pend
);
  logic                          used_r, used_nxt;
  logic [1:0]                    dev_r;
  logic [dts_pkg::MAX_TASKS-1:0] row_r, row_nxt;
  logic [dts_pkg::CW-1:0]        pend_r, pend_nxt;
  logic [dts_pkg::CW-1:0]        cnt;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < dts_pkg::MAX_TASKS; i++) cnt = cnt + dts_pkg::CW'(col_in[i]);
  end

  always_comb begin
    used_nxt = used_r;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    if (cmd.clear) begin
      used_nxt = 1'b0;
      row_nxt  = '0;
    end else begin
      if (cmd.add_en && cmd.add_slot == slot) used_nxt = 1'b1;
      if (cmd.edge_en && cmd.edge_row == slot) row_nxt = row_r | cmd.edge_bit;
    end
    if (cmd.cnt_load) begin
      pend_nxt = cnt;
    end else if (cmd.release_en && cmd.release_mask[slot] && pend_r != '0) begin
      pend_nxt = pend_r - dts_pkg::CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      row_r  <= '0;
      pend_r <= '0;
    end else begin
      used_r <= used_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_en && cmd.add_slot == slot && !cmd.clear) dev_r <= cmd.add_dev;
  end

  assign row_out = row_r;
  assign used    = used_r;
  assign dev     = dev_r;
  assign pend    = pend_r;
endmodule

// ===== design/dag_dependency_tracker_topo_sort_top.sv =====
// ---------------------------------------------------------------------------
// dag_dependency_tracker_topo_sort_top
// Bounded task dependency graph with cycle check and Kahn sort.
// ---------------------------------------------------------------------------
// Add task, clear and unknown funcs go from S_IDLE to S_OUT. Add edge grows
// the reachable set from the destination one frontier step per cycle in
// S_REACH. A degree query passes through S_DEG. A sort loads the in-degree
// counts into the cells, seeds the ready tasks, then each cycle either
// appends one ready task to the order queue or releases the successors of one
// queued task, and finally sends one word per sorted task, or a single word
// when none is ready. A result cycle waits while the output register is held
// by a stall. One item is in flight at a time; the output register lets the
// next item enter while a result waits.
module dag_dependency_tracker_topo_sort_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dts_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output dts_pkg::out_word_t out_word
);
  `include "dag_dependency_tracker_topo_sort_top_macros.svh"

  dts_pkg::state_t         state_r, state_nxt;
  dts_pkg::in_word_t       req_r, req_nxt;
  dts_pkg::out_word_t      out_r, out_nxt;
  logic                    out_v_r, out_v_nxt;
  logic [dts_pkg::IDW-1:0] next_id_r, next_id_nxt;
  logic [dts_pkg::MAX_TASKS-1:0] seen_r, seen_nxt;
  logic [dts_pkg::MAX_TASKS-1:0] newq_r, newq_nxt;
  logic [dts_pkg::SW-1:0]  ord_r   [dts_pkg::MAX_TASKS];
  logic [dts_pkg::SW-1:0]  ord_nxt [dts_pkg::MAX_TASKS];
  logic [dts_pkg::CW-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic                    acy_r, acy_nxt;
  logic [dts_pkg::SW-1:0]  idx_r, idx_nxt;

  dts_pkg::cell_cmd_t            cmd;
  logic [dts_pkg::MAX_TASKS-1:0] row  [dts_pkg::MAX_TASKS];
  logic [dts_pkg::MAX_TASKS-1:0] col  [dts_pkg::MAX_TASKS];
  logic [dts_pkg::MAX_TASKS-1:0] used;
  logic [1:0]                    dev  [dts_pkg::MAX_TASKS];
  logic [dts_pkg::CW-1:0]        pend [dts_pkg::MAX_TASKS];

  always_comb begin
    for (int c = 0; c < dts_pkg::MAX_TASKS; c++)
      for (int r = 0; r < dts_pkg::MAX_TASKS; r++) col[c][r] = row[r][c] & used[r];
  end

  genvar g;
  generate
    for (g = 0; g < dts_pkg::MAX_TASKS; g++) begin : g_cell
      dts_cell u_cell (
        .clk(clk), .rst_n(rst_n), .slot(dts_pkg::SW'(g)), .cmd(cmd),
        .col_in(col[g]), .row_out(row[g]), .used(used[g]), .dev(dev[g]),
        .pend(pend[g])
      );
    end
  endgenerate

  // combinational helpers
  logic                          from_ok, to_ok, out_free;
  logic [dts_pkg::SW-1:0]        fs, ts, low, cur;
  logic [dts_pkg::MAX_TASKS-1:0] grow, seed, relq;
  logic [dts_pkg::CW-1:0]        total, incnt, outcnt;

  assign fs = dts_pkg::SW'(req_r.from_id - 5'd1);
  assign ts = dts_pkg::SW'(req_r.to_id - 5'd1);
  assign from_ok = req_r.from_id != '0 && req_r.from_id <= 5'(dts_pkg::MAX_TASKS) &&
                   used[fs];
  assign to_ok   = req_r.to_id != '0 && req_r.to_id <= 5'(dts_pkg::MAX_TASKS) &&
                   used[ts];
  assign cur      = ord_r[head_r[dts_pkg::SW-1:0]];
  assign out_free = !out_v_r || !out_stall;

  always_comb begin
    grow = seen_r;
    total = '0;
    incnt = '0;
    outcnt = '0;
    for (int i = 0; i < dts_pkg::MAX_TASKS; i++) begin
      if (seen_r[i]) grow = grow | row[i];
      total   = total + dts_pkg::CW'(used[i]);
      incnt   = incnt + dts_pkg::CW'(row[i][fs]);
      outcnt  = outcnt + dts_pkg::CW'(row[fs][i]);
      seed[i] = used[i] && pend[i] == '0;
      // a successor whose last pending predecessor is released now
      relq[i] = row[cur][i] && used[i] && pend[i] == dts_pkg::CW'(1);
    end
    low = '0;
    for (int i = dts_pkg::MAX_TASKS - 1; i >= 0; i--) if (newq_r[i]) low = dts_pkg::SW'(i);
  end

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    out_nxt     = out_r;
    out_v_nxt   = out_v_r;
    next_id_nxt = next_id_r;
    seen_nxt    = seen_r;
    newq_nxt    = newq_r;
    ord_nxt     = ord_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    acy_nxt     = acy_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    in_stall    = 1'b1;
    if (out_v_r && !out_stall) out_v_nxt = 1'b0;

    unique case (state_r)
      dts_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          req_nxt = in_word;
          unique case (in_word.func)
            dts_pkg::FN_ADD_EDGE: state_nxt = dts_pkg::S_REACH;
            dts_pkg::FN_SORT:     state_nxt = dts_pkg::S_SCAN;
            dts_pkg::FN_DEGREE:   state_nxt = dts_pkg::S_DEG;
            default:              state_nxt = dts_pkg::S_OUT;
          endcase
          seen_nxt = '0;
          if (in_word.to_id != '0) seen_nxt[dts_pkg::SW'(in_word.to_id - 5'd1)] = 1'b1;
        end
      end
      dts_pkg::S_REACH: begin
        if (!from_ok || !to_ok || req_r.from_id == req_r.to_id || row[fs][ts]) begin
          state_nxt = dts_pkg::S_OUT;
        end else if (grow == seen_r || grow[fs]) begin
          seen_nxt = grow;
          state_nxt = dts_pkg::S_OUT;
        end else begin
          seen_nxt = grow;
        end
      end
      dts_pkg::S_DEG: state_nxt = dts_pkg::S_OUT;
      dts_pkg::S_SCAN: begin
        cmd.cnt_load = 1'b1;
        state_nxt = dts_pkg::S_SEED;
      end
      dts_pkg::S_SEED: begin
        newq_nxt = seed;
        head_nxt = '0;
        tail_nxt = '0;
        state_nxt = dts_pkg::S_SORT;
      end
      dts_pkg::S_SORT: begin
        // append newly ready tasks lowest id first, then release the next one
        priority if (newq_r != '0) begin
          ord_nxt[tail_r[dts_pkg::SW-1:0]] = low;
          tail_nxt = tail_r + dts_pkg::CW'(1);
          newq_nxt[low] = 1'b0;
        end else if (head_r != tail_r) begin
          cmd.release_en = 1'b1;
          cmd.release_mask = row[cur];
          newq_nxt = relq;
          head_nxt = head_r + dts_pkg::CW'(1);
        end else begin
          acy_nxt = (tail_r == total);
          idx_nxt = '0;
          state_nxt = dts_pkg::S_EMIT;
        end
      end
      dts_pkg::S_EMIT: begin
        if (out_free) begin
          out_nxt = '0;
          out_nxt.acyclic = acy_r;
          out_v_nxt = 1'b1;
          if (tail_r == '0) begin
            out_nxt.last = 1'b1;
            state_nxt = dts_pkg::S_IDLE;
          end else begin
            out_nxt.task_id = dts_pkg::IDW'(ord_r[idx_r]) + 5'd1;
            out_nxt.task_device = dev[ord_r[idx_r]];
            if (dts_pkg::CW'(idx_r) + dts_pkg::CW'(1) == tail_r) begin
              out_nxt.last = 1'b1;
              state_nxt = dts_pkg::S_IDLE;
            end else begin
              idx_nxt = idx_r + dts_pkg::SW'(1);
            end
          end
        end
      end
      dts_pkg::S_OUT: begin
        if (out_free) begin
          out_nxt = '0;
          out_nxt.last = 1'b1;
          out_v_nxt = 1'b1;
          state_nxt = dts_pkg::S_IDLE;
          unique case (req_r.func)
            dts_pkg::FN_ADD_TASK: begin
              if (next_id_r > dts_pkg::IDW'(dts_pkg::MAX_TASKS)) begin
                out_nxt.status = dts_pkg::ST_FULL;
              end else begin
                cmd.add_en = 1'b1;
                cmd.add_slot = dts_pkg::SW'(next_id_r - dts_pkg::IDW'(1));
                cmd.add_dev = req_r.device;
                out_nxt.task_id = next_id_r;
                out_nxt.task_device = req_r.device;
                next_id_nxt = next_id_r + dts_pkg::IDW'(1);
              end
            end
            dts_pkg::FN_ADD_EDGE: begin
              priority if (!from_ok || !to_ok) out_nxt.status = dts_pkg::ST_UNKNOWN;
              else if (req_r.from_id == req_r.to_id) out_nxt.status = dts_pkg::ST_REJECT;
              else if (row[fs][ts]) out_nxt.status = dts_pkg::ST_OK;
              else if (seen_r[fs]) out_nxt.status = dts_pkg::ST_REJECT;
              else begin
                cmd.edge_en = 1'b1;
                cmd.edge_row = fs;
                cmd.edge_bit[ts] = 1'b1;
              end
            end
            dts_pkg::FN_CLEAR: begin
              cmd.clear = 1'b1;
              next_id_nxt = dts_pkg::IDW'(1);
            end
            dts_pkg::FN_DEGREE: begin
              if (!from_ok) out_nxt.status = dts_pkg::ST_UNKNOWN;
              else begin
                out_nxt.task_id = req_r.from_id;
                out_nxt.task_device = dev[fs];
                out_nxt.in_count = dts_pkg::sat15(incnt);
                out_nxt.out_count = dts_pkg::sat15(outcnt);
              end
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = dts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dts_pkg::S_IDLE;
      out_v_r   <= 1'b0;
      next_id_r <= dts_pkg::IDW'(1);
    end else begin
      state_r   <= state_nxt;
      out_v_r   <= out_v_nxt;
      next_id_r <= next_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    out_r  <= out_nxt;
    seen_r <= seen_nxt;
    newq_r <= newq_nxt;
    ord_r  <= ord_nxt;
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    acy_r  <= acy_nxt;
    idx_r  <= idx_nxt;
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

  `DTS_ASSERT_IMP(a_idle_ready, state_r != dts_pkg::S_IDLE, in_stall)
  `DTS_ASSERT_NXT(a_accept_leaves_idle, in_valid && !in_stall, state_r != dts_pkg::S_IDLE)
  `DTS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
  `DTS_ASSERT_IMP(a_next_id_range, 1'b1, next_id_r != '0 && next_id_r <= dts_pkg::IDW'(17))
endmodule
